// ----- rtl/bba_pkg.sv -----
// bba_pkg: shared constants, codes and types for the block bitmap allocator
// no dependencies; used by the channel interfaces and the allocator top level
package bba_pkg;

    localparam int unsigned NUM_BLOCKS_DEF      = 32768;
    localparam int unsigned RESERVED_BLOCKS_DEF = 1036;
    localparam int unsigned WORD_BITS_DEF       = 64;

    localparam int unsigned ID_W  = 16;
    localparam int unsigned RES_W = 15;
    localparam int unsigned ST_W  = 2;

    // words per summary group in the first search stage
    localparam int unsigned GROUP_WORDS = 32;
    localparam int unsigned GROUP_BITS  = 5;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ASRCH,
        S_AMOD,
        S_FDIV,
        S_FMOD,
        S_RESP
    } t_state;

endpackage

// ----- rtl/bba_in_if.sv -----
// bba_in_if: command channel of the block bitmap allocator
// depends on bba_pkg for field widths
interface bba_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [bba_pkg::ID_W-1:0]    block_id;

    modport source (output valid, cmd, block_id, input ready);
    modport sink   (input valid, cmd, block_id, output ready);
endinterface

// ----- rtl/bba_out_if.sv -----
// bba_out_if: result channel of the block bitmap allocator
// depends on bba_pkg for field widths
interface bba_out_if;
    logic                        valid;
    logic                        ready;
    logic [bba_pkg::RES_W-1:0]   result_block;
    logic [bba_pkg::ST_W-1:0]    status;

    modport source (output valid, result_block, status, input ready);
    modport sink   (input valid, result_block, status, output ready);
endinterface

// ----- rtl/bba_ram.sv -----
// bba_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module bba_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 512,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/block_bitmap_allocator.sv -----
// block_bitmap_allocator: first-fit disk block allocator over a used/free bitmap
// depends on bba_pkg, bba_in_if, bba_out_if and bba_ram
//
// usage
//   i_cmd carries one command per transaction: cmd 0 allocates the lowest free
//   block, cmd 1 frees block_id. o_res returns exactly one transaction per
//   command: result_block and status (ok, full, free id out of range).
//   the bitmap lives in a ram of NUM_WORDS words of WORD_BITS bits; one full
//   flag per word sits in flops and feeds a two-stage first-fit search
//   (groups of 32 words, then across groups).
//   an allocate runs search and word read, set bit and write back, then result
//   load; when no word is free it goes from the search straight to the result
//   load. a free runs id split and word read, clear and write back, result
//   load. an out-of-range free goes straight to the result load. one command
//   is in flight at a time and the next is accepted in the idle cycle after the
//   result load.
//   after reset the block runs a fill pass over all NUM_WORDS words (512 at the
//   default size) that writes the reserved prefix into the ram; i_cmd.ready
//   stays low during it.
//   the result sits in an output register; a new command is accepted while it
//   waits, and the next command holds in its last step until the receiver
//   takes the pending result.
module block_bitmap_allocator #(
    parameter int unsigned NUM_BLOCKS      = bba_pkg::NUM_BLOCKS_DEF,
    parameter int unsigned RESERVED_BLOCKS = bba_pkg::RESERVED_BLOCKS_DEF,
    parameter int unsigned WORD_BITS       = bba_pkg::WORD_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bba_in_if.sink          i_cmd,
    bba_out_if.source       o_res
);

    localparam int unsigned NW      = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW      = (NW > 1) ? $clog2(NW) : 1;
    localparam int unsigned BW      = $clog2(WORD_BITS);
    localparam int unsigned G       = bba_pkg::GROUP_WORDS;
    localparam int unsigned GB      = bba_pkg::GROUP_BITS;
    localparam int unsigned NG      = (NW + G - 1) / G;
    localparam int unsigned NGW     = (NG > 1) ? $clog2(NG) : 1;
    localparam int unsigned BASE_W  = AW + BW + 1;
    localparam int unsigned BLK_W   = AW + BW;
    localparam int unsigned RES_EFF =
        (RESERVED_BLOCKS < NUM_BLOCKS) ? RESERVED_BLOCKS : NUM_BLOCKS;
    localparam int unsigned ID_W    = bba_pkg::ID_W;
    // reciprocal for the id split: floor(2^SH / WORD_BITS), error at most one
    localparam int unsigned SH      = ID_W + BW;
    localparam longint unsigned RECIP = (64'd1 << SH) / WORD_BITS;
    localparam int unsigned MW      = ID_W + 2;
    localparam int unsigned PW      = ID_W + MW;

    function automatic logic [NW-1:0] f_init_full();
        logic [NW-1:0]   v;
        longint unsigned base;
        longint unsigned lim;
        v = '0;
        for (int w = 0; w < NW; w++) begin
            base = longint'(w) * WORD_BITS;
            lim  = (base + WORD_BITS < NUM_BLOCKS) ? base + WORD_BITS : NUM_BLOCKS;
            v[w] = (RESERVED_BLOCKS >= lim);
        end
        return v;
    endfunction

    localparam logic [NW-1:0] INIT_FULL = f_init_full();

    bba_pkg::t_state r_state, n_state;

    logic [AW-1:0]          r_cnt;
    logic [BASE_W-1:0]      r_base;
    logic [NW-1:0]          r_full;
    logic                   r_out_valid;
    logic [bba_pkg::RES_W-1:0] r_out_blk;
    logic [bba_pkg::ST_W-1:0]  r_out_st;

    logic [bba_pkg::RES_W-1:0] r_res_blk;
    logic [bba_pkg::ST_W-1:0]  r_res_st;
    logic [ID_W-1:0]        r_id;
    logic [PW-1:0]          r_prod;
    logic [AW-1:0]          r_addr;
    logic [BW-1:0]          r_bit;

    logic                   r_g_any [NG];
    logic [GB-1:0]          r_g_low [NG];
    logic                   n_g_any [NG];
    logic [GB-1:0]          n_g_low [NG];

    logic [NG*G-1:0]        full_pad;
    logic                   hit;
    logic [NGW-1:0]         gsel;
    logic [AW-1:0]          word_sel;

    logic [WORD_BITS-1:0]   init_word;
    logic [BW-1:0]          zbit;
    logic [BLK_W-1:0]       blk;

    logic [ID_W-1:0]        q_raw;
    logic [ID_W:0]          qwb;
    logic [ID_W:0]          rem_raw;
    logic [ID_W-1:0]        q_fix;
    logic [BW-1:0]          rem_fix;

    logic                   accept;
    logic                   id_range;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign id_range = ({{($bits(NUM_BLOCKS) - ID_W){1'b0}}, i_cmd.block_id} >= NUM_BLOCKS);

    // first search stage: lowest non-full word per group, refreshed every cycle
    always_comb begin
        full_pad = '1;
        for (int i = 0; i < NW; i++) begin
            full_pad[i] = r_full[i];
        end
    end

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_g_any[g] = 1'b0;
            n_g_low[g] = '0;
            for (int k = G - 1; k >= 0; k--) begin
                if (!full_pad[g*G + k]) begin
                    n_g_any[g] = 1'b1;
                    n_g_low[g] = GB'(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_any <= n_g_any;
        r_g_low <= n_g_low;
    end

    // second search stage: lowest group with a free word
    always_comb begin
        hit  = 1'b0;
        gsel = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_g_any[g]) begin
                hit  = 1'b1;
                gsel = NGW'(g);
            end
        end
        word_sel = AW'({gsel, r_g_low[gsel]});
    end

    // reset contents of the word at the fill pointer
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            init_word[b] = ((r_base + BASE_W'(b)) < BASE_W'(RES_EFF)) ||
                           ((r_base + BASE_W'(b)) >= BASE_W'(NUM_BLOCKS));
        end
    end

    // lowest clear bit of the word just read
    always_comb begin
        zbit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!ram_rdata[b]) begin
                zbit = BW'(b);
            end
        end
        blk = BLK_W'(r_addr) * BLK_W'(WORD_BITS) + BLK_W'(zbit);
    end

    // id split into word and bit with one correction step
    always_comb begin
        q_raw   = ID_W'(r_prod >> SH);
        qwb     = (ID_W + 1)'(q_raw) * (ID_W + 1)'(WORD_BITS);
        rem_raw = {1'b0, r_id} - qwb;
        if (rem_raw >= (ID_W + 1)'(WORD_BITS)) begin
            q_fix   = q_raw + 1'b1;
            rem_fix = BW'(rem_raw - (ID_W + 1)'(WORD_BITS));
        end else begin
            q_fix   = q_raw;
            rem_fix = BW'(rem_raw);
        end
    end

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = ram_rdata;
        ram_raddr = r_addr;
        case (r_state)
            bba_pkg::S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = init_word;
                if (r_cnt == AW'(NW - 1)) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_cmd.cmd == bba_pkg::CMD_ALLOC) begin
                        n_state = bba_pkg::S_ASRCH;
                    end else if (id_range) begin
                        n_state = bba_pkg::S_RESP;
                    end else begin
                        n_state = bba_pkg::S_FDIV;
                    end
                end
            end
            bba_pkg::S_ASRCH: begin
                ram_raddr = word_sel;
                n_state   = hit ? bba_pkg::S_AMOD : bba_pkg::S_RESP;
            end
            bba_pkg::S_AMOD: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | (WORD_BITS'(1) << zbit);
                n_state   = bba_pkg::S_RESP;
            end
            bba_pkg::S_FDIV: begin
                ram_raddr = AW'(q_fix);
                n_state   = bba_pkg::S_FMOD;
            end
            bba_pkg::S_FMOD: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~(WORD_BITS'(1) << r_bit);
                n_state   = bba_pkg::S_RESP;
            end
            bba_pkg::S_RESP: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_base      <= '0;
            r_full      <= INIT_FULL;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == bba_pkg::S_INIT) begin
                r_cnt  <= r_cnt + 1'b1;
                r_base <= r_base + BASE_W'(WORD_BITS);
            end
            if (ram_we && (r_state != bba_pkg::S_INIT)) begin
                r_full[r_addr] <= (ram_wdata == '1);
            end
            if (r_state == bba_pkg::S_RESP && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id      <= i_cmd.block_id;
            r_prod    <= PW'(i_cmd.block_id) * PW'(MW'(RECIP));
            r_res_blk <= '0;
            r_res_st  <= (i_cmd.cmd == bba_pkg::CMD_FREE && id_range) ?
                         bba_pkg::ST_RANGE : bba_pkg::ST_OK;
        end
        if (r_state == bba_pkg::S_ASRCH) begin
            r_addr <= word_sel;
            if (!hit) begin
                r_res_st <= bba_pkg::ST_FULL;
            end
        end
        if (r_state == bba_pkg::S_FDIV) begin
            r_addr <= AW'(q_fix);
            r_bit  <= rem_fix;
        end
        if (r_state == bba_pkg::S_AMOD) begin
            r_res_blk <= bba_pkg::RES_W'(blk);
        end
        if (r_state == bba_pkg::S_RESP && (!r_out_valid || o_res.ready)) begin
            r_out_blk <= r_res_blk;
            r_out_st  <= r_res_st;
        end
    end

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NW),
        .AW    (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_cmd.ready        = (r_state == bba_pkg::S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.result_block = r_out_blk;
    assign o_res.status       = r_out_st;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_cmd.ready)
        else $error("command accepted while another is in flight");

    a_alloc_sets_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::S_AMOD) |-> (ram_wdata != ram_rdata))
        else $error("allocate wrote back a word without setting a bit");

    a_alloc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::S_AMOD) |-> ({{(32 - BLK_W){1'b0}}, blk} < NUM_BLOCKS))
        else $error("allocated block number beyond block count");

endmodule
